### rtl/core/socu_pkg.sv
// ----------------------------------------------------------------------------
// socu_pkg
// Shared types and constants for the subsequence occurrence counter.
// ----------------------------------------------------------------------------
package socu_pkg;

    localparam int MAX_PATTERN_DEF   = 24;
    localparam int COUNT_MODULUS_DEF = 10000;
    localparam int QUEUE_DEPTH_DEF   = 2;

    localparam int CHAR_W    = 8;
    localparam int MATCH_W   = 14;
    localparam int LEN_W     = 5;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int PAT_BANKS = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_LOW  = 2'd0,
        REG_PAT_MID  = 2'd1,
        REG_PAT_HIGH = 2'd2,
        REG_PAT_LEN  = 2'd3
    } cfg_reg_t;

endpackage

### rtl/core/socu_front.sv
// ----------------------------------------------------------------------------
// socu_front
// Holds the pattern registers and classifies each text word into a per-prefix
// match vector, a restart flag and the selected output prefix.
// ----------------------------------------------------------------------------
module socu_front #(
    parameter int MAX_PATTERN = socu_pkg::MAX_PATTERN_DEF,
    parameter int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [socu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [socu_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           text_valid,
    output logic                           text_ready,
    input  logic [socu_pkg::CHAR_W-1:0]    text_char,
    input  logic                           start_text,
    output logic                           q_valid,
    input  logic                           q_ready,
    output logic [IDX_W+MAX_PATTERN:0]     q_data
);

    logic [socu_pkg::CFG_W-1:0] pat_low_reg, pat_low_next;
    logic [socu_pkg::CFG_W-1:0] pat_mid_reg, pat_mid_next;
    logic [socu_pkg::CFG_W-1:0] pat_high_reg, pat_high_next;
    logic [socu_pkg::LEN_W-1:0] pat_len_reg, pat_len_next;

    logic [socu_pkg::PAT_BANKS*socu_pkg::CFG_W-1:0] pat_flat;
    logic [MAX_PATTERN-1:0]     match_vec;
    logic [socu_pkg::LEN_W-1:0] len_clamp;
    logic [socu_pkg::LEN_W-1:0] sel_wide;

    always_comb
    begin
        pat_low_next  = pat_low_reg;
        pat_mid_next  = pat_mid_reg;
        pat_high_next = pat_high_reg;
        pat_len_next  = pat_len_reg;
        if (cfg_we)
        begin
            unique case (socu_pkg::cfg_reg_t'(cfg_index))
                socu_pkg::REG_PAT_LOW:  pat_low_next  = cfg_data;
                socu_pkg::REG_PAT_MID:  pat_mid_next  = cfg_data;
                socu_pkg::REG_PAT_HIGH: pat_high_next = cfg_data;
                socu_pkg::REG_PAT_LEN:  pat_len_next  = cfg_data[socu_pkg::LEN_W-1:0];
                default:                pat_len_next  = pat_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_mid_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= socu_pkg::LEN_W'(1);
        end
        else
        begin
            pat_low_reg  <= pat_low_next;
            pat_mid_reg  <= pat_mid_next;
            pat_high_reg <= pat_high_next;
            pat_len_reg  <= pat_len_next;
        end
    end

    assign pat_flat = {pat_high_reg, pat_mid_reg, pat_low_reg};

    for (genvar j = 0; j < MAX_PATTERN; j++)
    begin : g_cmp
        assign match_vec[j] =
            (pat_flat[j*socu_pkg::CHAR_W +: socu_pkg::CHAR_W] == text_char);
    end

    // zero length acts as one, oversize saturates
    always_comb
    begin
        len_clamp = pat_len_reg;
        if (pat_len_reg == '0)
            len_clamp = socu_pkg::LEN_W'(1);
        else if (pat_len_reg > socu_pkg::LEN_W'(MAX_PATTERN))
            len_clamp = socu_pkg::LEN_W'(MAX_PATTERN);
        sel_wide = len_clamp - socu_pkg::LEN_W'(1);
    end

    assign text_ready = q_ready;
    assign q_valid    = text_valid;
    assign q_data     = {sel_wide[IDX_W-1:0], start_text, match_vec};

endmodule

### rtl/core/socu_queue.sv
// ----------------------------------------------------------------------------
// socu_queue
// Small register FIFO between the classify front and the counting back.
// ----------------------------------------------------------------------------
module socu_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = socu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_data;
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count exceeds depth");
`endif

endmodule

### rtl/core/socu_back.sv
// ----------------------------------------------------------------------------
// socu_back
// Prefix count array: applies one classified word per cycle while the output is
// not stalled and registers the selected full-pattern count for the output channel.
// ----------------------------------------------------------------------------
module socu_back #(
    parameter int MAX_PATTERN   = socu_pkg::MAX_PATTERN_DEF,
    parameter int COUNT_MODULUS = socu_pkg::COUNT_MODULUS_DEF,
    parameter int IDX_W         = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  logic [IDX_W+MAX_PATTERN:0]   q_data,
    output logic                         count_valid,
    input  logic                         count_ready,
    output logic [socu_pkg::MATCH_W-1:0] match_count
);

    localparam int CNT_W = $clog2(COUNT_MODULUS);
    localparam logic [CNT_W:0] MOD_C = (CNT_W + 1)'(COUNT_MODULUS);

    logic [CNT_W-1:0] cnt_reg  [MAX_PATTERN];
    logic [CNT_W-1:0] cnt_next [MAX_PATTERN];
    logic [CNT_W-1:0] cnt_upd  [MAX_PATTERN];

    logic                         valid_reg, valid_next;
    logic [socu_pkg::MATCH_W-1:0] match_reg;
    logic [CNT_W+socu_pkg::MATCH_W-1:0] sel_ext;

    logic [MAX_PATTERN-1:0] hit;
    logic                   restart;
    logic [IDX_W-1:0]       sel;
    logic                   pop;

    assign hit     = q_data[MAX_PATTERN-1:0];
    assign restart = q_data[MAX_PATTERN];
    assign sel     = q_data[IDX_W+MAX_PATTERN:MAX_PATTERN+1];

    assign q_ready = !valid_reg || count_ready;
    assign pop     = q_valid && q_ready;

    for (genvar j = 0; j < MAX_PATTERN; j++)
    begin : g_cell
        logic [CNT_W-1:0] base;
        logic [CNT_W-1:0] prev;
        logic [CNT_W:0]   sum;
        logic [CNT_W:0]   red;

        assign base = restart ? '0 : cnt_reg[j];
        if (j == 0)
        begin : g_first
            assign prev = CNT_W'(1);
        end
        else
        begin : g_rest
            assign prev = restart ? '0 : cnt_reg[j-1];
        end
        assign sum        = {1'b0, base} + {1'b0, prev};
        assign red        = (sum >= MOD_C) ? sum - MOD_C : sum;
        assign cnt_upd[j] = hit[j] ? red[CNT_W-1:0] : base;
        assign cnt_next[j] = pop ? cnt_upd[j] : cnt_reg[j];
    end

    assign sel_ext    = {{socu_pkg::MATCH_W{1'b0}}, cnt_upd[sel]};
    assign valid_next = pop ? 1'b1 : (count_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            for (int k = 0; k < MAX_PATTERN; k++)
                cnt_reg[k] <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            for (int k = 0; k < MAX_PATTERN; k++)
                cnt_reg[k] <= cnt_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            match_reg <= sel_ext[socu_pkg::MATCH_W-1:0];
    end

    assign count_valid = valid_reg;
    assign match_count = match_reg;

`ifndef NO_ASSERTIONS
    a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> valid_reg)
        else $error("popped word did not reach the output register");

    a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ({{(CNT_W + 1){1'b0}}, match_reg} < {{socu_pkg::MATCH_W{1'b0}}, MOD_C}))
        else $error("output count not reduced");

    a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && restart && !hit[0]) |=> (match_reg == '0))
        else $error("restart without first-character hit must give zero");
`endif

endmodule

### rtl/core/subsequence_occurrence_counter_unit.sv
// ----------------------------------------------------------------------------
// subsequence_occurrence_counter_unit
// Counts occurrences of a configured pattern as a subsequence of a text stream.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write pattern bytes (three 64-bit banks) and the pattern
//   length through cfg_we / cfg_index / cfg_data, only while the unit is idle.
//   Text channel: text_valid / text_ready carries one character per word;
//   start_text restarts all prefix counts ahead of that character.
//   Count channel: count_valid / count_ready returns one match_count per text
//   word, in order: the full-pattern count so far, modulo COUNT_MODULUS.
//   Path: an accepted word is written into the queue, then popped into the output register that holds its count.
//   Throughput: one word per cycle while count_ready is not held low, set by the
//   parallel prefix adder array, which updates all prefix counts together.
//   Stall: the output register holds while count_ready is low; a two-entry
//   queue absorbs the words in flight, then text_ready drops.
//   Reset: counts clear to zero, pattern bytes to zero, length to one; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module subsequence_occurrence_counter_unit #(
    parameter int MAX_PATTERN   = socu_pkg::MAX_PATTERN_DEF,
    parameter int COUNT_MODULUS = socu_pkg::COUNT_MODULUS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [socu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [socu_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           text_valid,
    output logic                           text_ready,
    input  logic [socu_pkg::CHAR_W-1:0]    text_char,
    input  logic                           start_text,
    output logic                           count_valid,
    input  logic                           count_ready,
    output logic [socu_pkg::MATCH_W-1:0]   match_count
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int QW    = IDX_W + MAX_PATTERN + 1;

    logic          fq_valid;
    logic          fq_ready;
    logic [QW-1:0] fq_data;
    logic          qb_valid;
    logic          qb_ready;
    logic [QW-1:0] qb_data;

    socu_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .IDX_W       (IDX_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text_char  (text_char),
        .start_text (start_text),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready),
        .q_data     (fq_data)
    );

    socu_queue #(
        .WIDTH (QW),
        .DEPTH (socu_pkg::QUEUE_DEPTH_DEF)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    socu_back #(
        .MAX_PATTERN   (MAX_PATTERN),
        .COUNT_MODULUS (COUNT_MODULUS),
        .IDX_W         (IDX_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (qb_valid),
        .q_ready     (qb_ready),
        .q_data      (qb_data),
        .count_valid (count_valid),
        .count_ready (count_ready),
        .match_count (match_count)
    );

endmodule

### tb/sv/socu_match_count_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// socu_match_count_check
// Watches the configuration port and both channels of the subsequence
// occurrence counter. It keeps its own copy of the pattern and of the prefix
// counts, predicts the count for every accepted text word, and compares each
// returned count with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module socu_match_count_check (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [socu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [socu_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           text_valid,
    input  logic                           text_ready,
    input  logic [socu_pkg::CHAR_W-1:0]    text_char,
    input  logic                           start_text,
    input  logic                           count_valid,
    input  logic                           count_ready,
    input  logic [socu_pkg::MATCH_W-1:0]   match_count,
    output int                             mismatches,
    output int                             pending
);
    import socu_pkg::*;

    logic [CFG_W-1:0]   pat_low;
    logic [CFG_W-1:0]   pat_mid;
    logic [CFG_W-1:0]   pat_high;
    logic [LEN_W-1:0]   pat_len;
    logic [MATCH_W-1:0] prefix_tally [MAX_PATTERN_DEF];
    logic [MATCH_W-1:0] expected_counts [$];
    logic [MATCH_W-1:0] want;

    function automatic logic [CHAR_W-1:0] pattern_byte(input int pos);
        logic [3*CFG_W-1:0] flat;
        flat = {pat_high, pat_mid, pat_low};
        return flat[pos*CHAR_W +: CHAR_W];
    endfunction

    // All prefixes update from the old counts, so walk from the longest down.
    function automatic logic [MATCH_W-1:0] predict_match_count(
        input logic [CHAR_W-1:0] ch,
        input logic              clear
    );
        int sum;
        int eff_len;
        if (clear)
        begin
            for (int k = 0; k < MAX_PATTERN_DEF; k++)
                prefix_tally[k] = '0;
        end
        for (int j = MAX_PATTERN_DEF - 1; j >= 0; j--)
        begin
            if (pattern_byte(j) == ch)
            begin
                sum = int'(prefix_tally[j]) + ((j == 0) ? 1 : int'(prefix_tally[j-1]));
                if (sum >= COUNT_MODULUS_DEF)
                    sum -= COUNT_MODULUS_DEF;
                prefix_tally[j] = sum[MATCH_W-1:0];
            end
        end
        eff_len = int'(pat_len);
        if (eff_len == 0)
            eff_len = 1;
        if (eff_len > MAX_PATTERN_DEF)
            eff_len = MAX_PATTERN_DEF;
        return prefix_tally[eff_len-1];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low  = '0;
            pat_mid  = '0;
            pat_high = '0;
            pat_len  = LEN_W'(1);
            for (int k = 0; k < MAX_PATTERN_DEF; k++)
                prefix_tally[k] = '0;
            expected_counts.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PAT_LOW:  pat_low  = cfg_data;
                    REG_PAT_MID:  pat_mid  = cfg_data;
                    REG_PAT_HIGH: pat_high = cfg_data;
                    REG_PAT_LEN:  pat_len  = cfg_data[LEN_W-1:0];
                    default:      ;
                endcase
            end
            if (text_valid && text_ready)
                expected_counts.push_back(predict_match_count(text_char, start_text));
            if (count_valid && count_ready)
            begin
                if (expected_counts.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected count word, match_count %0d",
                                 $time, match_count);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (want !== match_count)
                    begin
                        if (mismatches < 10)
                            $display("%0t: match_count expected %0d, actual %0d",
                                     $time, want, match_count);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending <= expected_counts.size();
        end
    end

endmodule

### tb/sv/subsequence_occurrence_counter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subsequence_occurrence_counter_unit_tb
// Drives text words through the counter under several pattern settings: a
// short directed run over the corner cases, then random phases built mostly
// from the pattern's own characters so counts grow and wrap. The sender
// idles in bursts and the receiver stalls on its own pattern; a separate
// checker predicts and compares every count word.
// ----------------------------------------------------------------------------
module subsequence_occurrence_counter_unit_tb;
    import socu_pkg::*;

    localparam int TIMEOUT_CYCLES = 200000;
    localparam int RANDOM_WORDS   = 400;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 text_valid;
    logic                 text_ready;
    logic [CHAR_W-1:0]    text_char;
    logic                 start_text;
    logic                 count_valid;
    logic                 count_ready = 1'b0;
    logic [MATCH_W-1:0]   match_count;

    int                   mismatches;
    int                   pending;
    int                   burst_left = 0;
    int                   random_words;
    int                   phase_words;
    logic [9:0]           stall_phase = '0;

    subsequence_occurrence_counter_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text_char   (text_char),
        .start_text  (start_text),
        .count_valid (count_valid),
        .count_ready (count_ready),
        .match_count (match_count)
    );

    socu_match_count_check i_count_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text_char   (text_char),
        .start_text  (start_text),
        .count_valid (count_valid),
        .count_ready (count_ready),
        .match_count (match_count),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: ready pattern changes with the upper bits of stall_phase.
    always @(negedge clk)
    begin
        stall_phase <= stall_phase + 10'd1;
        case (stall_phase[9:7])
            3'd0, 3'd1: count_ready <= 1'b1;
            3'd2:       count_ready <= 1'($urandom_range(0, 1));
            3'd3:       count_ready <= ($urandom_range(0, 3) == 0);
            3'd4:       count_ready <= stall_phase[2];
            3'd5:       count_ready <= (stall_phase[5:0] > 6'd40);
            default:    count_ready <= ($urandom_range(0, 4) != 0);
        endcase
    end

    task automatic send_text(input logic [CHAR_W-1:0] ch, input logic restart);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                text_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        text_valid <= 1'b1;
        text_char  <= ch;
        start_text <= restart;
        do
            @(posedge clk);
        while (!text_ready);
        @(negedge clk);
    endtask

    task automatic drain_counts();
        text_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] mid,
                             input logic [CFG_W-1:0] hi, input logic [LEN_W-1:0] len);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PAT_LOW;
        cfg_data  <= lo;
        @(negedge clk);
        cfg_index <= REG_PAT_MID;
        cfg_data  <= mid;
        @(negedge clk);
        cfg_index <= REG_PAT_HIGH;
        cfg_data  <= hi;
        @(negedge clk);
        cfg_index <= REG_PAT_LEN;
        cfg_data  <= CFG_W'(len);
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_random_phase(output int words_sent);
        logic [CHAR_W-1:0]  alph [4];
        logic [3*CFG_W-1:0] pat;
        logic [LEN_W-1:0]   len;
        logic [CHAR_W-1:0]  ch;
        int                 nsym;
        int                 kind;
        int                 eff_len;
        int                 pick;
        int                 nwords;
        kind = $urandom_range(0, 9);
        nsym = $urandom_range(1, 4);
        for (int k = 0; k < 4; k++)
            alph[k] = CHAR_W'($urandom_range(0, 255));
        if (kind == 0)
        begin
            alph[0] = 8'h00;
            alph[1] = 8'hFF;
        end
        for (int p = 0; p < MAX_PATTERN_DEF; p++)
            pat[p*CHAR_W +: CHAR_W] = alph[$urandom_range(0, nsym - 1)];
        if (kind == 1)
            pat = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        pick = $urandom_range(0, 19);
        if (pick == 0)
            len = '0;
        else if (pick == 1)
            len = LEN_W'($urandom_range(25, 31));
        else if (pick < 5)
            len = LEN_W'(MAX_PATTERN_DEF);
        else if (pick < 12)
            len = LEN_W'($urandom_range(1, 4));
        else
            len = LEN_W'($urandom_range(1, 24));
        eff_len = (len == 0) ? 1 : ((len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(len));
        nwords = $urandom_range(20, 60);
        drain_counts();
        configure(pat[CFG_W-1:0], pat[2*CFG_W-1:CFG_W], pat[3*CFG_W-1:2*CFG_W], len);
        for (int w = 0; w < nwords; w++)
        begin
            if ($urandom_range(0, 6) == 0)
                ch = CHAR_W'($urandom_range(0, 255));
            else
                ch = pat[$urandom_range(0, eff_len - 1)*CHAR_W +: CHAR_W];
            send_text(ch, (w == 0) ? 1'($urandom_range(0, 1))
                                   : ($urandom_range(0, 39) == 0));
        end
        words_sent = nwords;
    endtask

    initial
    begin
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_PAT_LOW;
        cfg_data    = '0;
        text_valid  = 1'b0;
        text_char   = '0;
        start_text  = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset pattern: all zero bytes, length one
        send_text(8'h00, 1'b1);
        send_text(8'hFF, 1'b0);
        send_text(8'h00, 1'b0);

        // length zero acts as one
        drain_counts();
        configure(64'h0000_0000_0063_6261, '1, '0, 5'd0);
        send_text(8'h61, 1'b1);
        send_text(8'h62, 1'b0);
        send_text(8'h61, 1'b0);

        // new length without a restart keeps the counts
        drain_counts();
        configure(64'h0000_0000_0063_6261, '1, '0, 5'd3);
        send_text(8'h63, 1'b0);
        send_text(8'h62, 1'b0);
        send_text(8'h63, 1'b0);

        // length above the maximum saturates
        drain_counts();
        configure('1, '1, '0, 5'd31);
        send_text(8'hFF, 1'b1);
        send_text(8'hFF, 1'b0);
        send_text(8'hFF, 1'b0);
        send_text(8'h00, 1'b0);

        drain_counts();
        configure('1, '1, '1, 5'd24);
        send_text(8'hFE, 1'b0);
        send_text(8'h7F, 1'b0);

        random_words = 0;
        while (random_words < RANDOM_WORDS)
        begin
            run_random_phase(phase_words);
            random_words += phase_words;
        end

        drain_counts();
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
